[rtl/clnw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, constants and tables for the character LCD nibble writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_PULSE_TICKS     = 2'd0;
    localparam logic [1:0] CFG_CHAR_WAIT_TICKS = 2'd1;
    localparam logic [1:0] CFG_HOME_WAIT_TICKS = 2'd2;
    localparam logic [1:0] CFG_TICKS_PER_MS    = 2'd3;

    // Register reset values
    localparam logic [7:0]  PULSE_TICKS_RST     = 8'd1;
    localparam logic [15:0] CHAR_WAIT_TICKS_RST = 16'd50;
    localparam logic [15:0] HOME_WAIT_TICKS_RST = 16'd2000;
    localparam logic [15:0] TICKS_PER_MS_RST    = 16'd1000;

    // Widths of the sequencer state
    localparam int CNT_W  = 22;
    localparam int STEP_W = 4;

    // Power-on sequence steps: four reset nibbles, then five commands
    localparam logic [STEP_W-1:0] INIT_CMD_FIRST = 4'd4;
    localparam logic [STEP_W-1:0] INIT_DONE      = 4'd9;
    localparam logic [STEP_W-1:0] INIT_LAST_NIB  = 4'd3;

    // Reset nibbles, placed in the high nibble of the held byte
    localparam logic [7:0] RESET_BYTE_3 = 8'h30;
    localparam logic [7:0] RESET_BYTE_2 = 8'h20;

    // Command bits that select the long wait
    localparam logic [7:0] HOME_MASK = 8'h03;

    // Extra ticks after the last reset nibble
    localparam logic [16:0] LAST_NIB_EXTRA = 17'd10;

    // One result item
    typedef struct packed {
        logic [3:0] lcd_nibble;
        logic       lcd_rs;
        logic       lcd_e;
        logic       ready_res;
    } t_result;

    // Commands sent after the reset nibbles
    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h2E;
            3'd1:    v = 8'h08;
            3'd2:    v = 8'h0D;
            3'd3:    v = 8'h06;
            3'd4:    v = 8'h02;
            default: v = 8'h02;
        endcase
        return v;
    endfunction

endpackage

[rtl/char_lcd_nibble_writer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_core
// 4-bit character LCD write sequencer with power-on initialization.
//
// Channel | Handshake                | Payload
// --------+--------------------------+-----------------------------------------
// in      | i_in_valid / o_in_ready  | i_request, i_mode, i_byte_value
// out     | o_out_valid / i_out_ready| o_lcd_nibble, o_lcd_rs, o_lcd_e,
//         |                          | o_ready_res
// cfg     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item (one tick) is taken per cycle while o_in_ready is high; its result
// is registered and appears the cycle after acceptance unless the output is
// stalled and full. The rate is set by the state update of the sequencer
// (counter increment and threshold compare). A two-entry result buffer takes
// one result while output stalls; o_in_ready drops only when both are full.
// Synchronous active-low reset starts the power-on wait; cfg is always ready.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_core
    import clnw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_request,
    input  logic        i_mode,
    input  logic [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_lcd_nibble,
    output logic        o_lcd_rs,
    output logic        o_lcd_e,
    output logic        o_ready_res,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Sequencer phase codes
    localparam logic [2:0] PH_POWER  = 3'd0;
    localparam logic [2:0] PH_SETUP  = 3'd1;
    localparam logic [2:0] PH_STROBE = 3'd2;
    localparam logic [2:0] PH_GAP    = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    logic [7:0]        r_pulse_ticks;
    logic [15:0]       r_char_wait;
    logic [15:0]       r_home_wait;
    logic [15:0]       r_ticks_per_ms;

    logic [2:0]        r_phase,       n_phase;
    logic [CNT_W-1:0]  r_wait_count,  n_wait_count;
    logic [7:0]        r_held_byte,   n_held_byte;
    logic              r_held_rs,     n_held_rs;
    logic              r_second,      n_second;
    logic [STEP_W-1:0] r_init_step,   n_init_step;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    logic              in_accept;
    logic              out_pop;
    t_result           new_res;

    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  power_thr;
    logic [CNT_W-1:0]  gap_thr;
    logic [CNT_W-1:0]  pulse_thr;
    logic [18:0]       five_ms;
    logic [16:0]       ms_plus;
    logic [STEP_W-1:0] step_inc;
    logic [2:0]        cmd_off;

    // Configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks  <= PULSE_TICKS_RST;
            r_char_wait    <= CHAR_WAIT_TICKS_RST;
            r_home_wait    <= HOME_WAIT_TICKS_RST;
            r_ticks_per_ms <= TICKS_PER_MS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PULSE_TICKS:     r_pulse_ticks  <= i_cfg_data[7:0];
                CFG_CHAR_WAIT_TICKS: r_char_wait    <= i_cfg_data;
                CFG_HOME_WAIT_TICKS: r_home_wait    <= i_cfg_data;
                CFG_TICKS_PER_MS:    r_ticks_per_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Thresholds; a zero time compares like one tick since the count is at least one
    assign power_thr = {1'b0, r_ticks_per_ms, 5'b0} + {3'b0, r_ticks_per_ms, 3'b0};
    assign five_ms   = {1'b0, r_ticks_per_ms, 2'b0} + {3'b0, r_ticks_per_ms};
    assign ms_plus   = {1'b0, r_ticks_per_ms} + LAST_NIB_EXTRA;
    assign pulse_thr = {{(CNT_W-8){1'b0}}, r_pulse_ticks};
    assign cnt_inc   = r_wait_count + {{(CNT_W-1){1'b0}}, 1'b1};
    assign step_inc  = r_init_step + {{(STEP_W-1){1'b0}}, 1'b1};
    assign cmd_off   = step_inc[2:0] - INIT_CMD_FIRST[2:0];

    always_comb begin
        if (r_init_step == '0) begin
            gap_thr = {{(CNT_W-19){1'b0}}, five_ms};
        end else if (r_init_step == INIT_LAST_NIB) begin
            gap_thr = {{(CNT_W-17){1'b0}}, ms_plus};
        end else if (r_init_step < INIT_CMD_FIRST) begin
            gap_thr = {{(CNT_W-16){1'b0}}, r_ticks_per_ms};
        end else if (!r_held_rs && ((r_held_byte & HOME_MASK) != 8'h00)) begin
            gap_thr = {{(CNT_W-16){1'b0}}, r_home_wait};
        end else begin
            gap_thr = {{(CNT_W-16){1'b0}}, r_char_wait};
        end
    end

    // Next sequencer state for one tick
    always_comb begin
        n_phase      = r_phase;
        n_wait_count = cnt_inc;
        n_held_byte  = r_held_byte;
        n_held_rs    = r_held_rs;
        n_second     = r_second;
        n_init_step  = r_init_step;
        case (r_phase)
            PH_POWER: begin
                if (cnt_inc >= power_thr) begin
                    n_init_step  = '0;
                    n_held_byte  = RESET_BYTE_3;
                    n_held_rs    = 1'b0;
                    n_second     = 1'b0;
                    n_phase      = PH_SETUP;
                    n_wait_count = '0;
                end
            end
            PH_SETUP: begin
                if (cnt_inc >= pulse_thr) begin
                    n_phase      = PH_STROBE;
                    n_wait_count = '0;
                end
            end
            PH_STROBE: begin
                if (cnt_inc >= pulse_thr) begin
                    n_wait_count = '0;
                    if (r_init_step >= INIT_CMD_FIRST && !r_second) begin
                        n_second = 1'b1;
                        n_phase  = PH_SETUP;
                    end else begin
                        n_phase  = PH_GAP;
                    end
                end
            end
            PH_GAP: begin
                if (cnt_inc >= gap_thr) begin
                    n_wait_count = '0;
                    if (r_init_step < INIT_DONE) begin
                        n_init_step = step_inc;
                        if (step_inc < INIT_DONE) begin
                            // start the next power-on nibble or command
                            if (step_inc < INIT_CMD_FIRST) begin
                                n_held_byte = (step_inc == INIT_LAST_NIB) ?
                                              RESET_BYTE_2 : RESET_BYTE_3;
                            end else begin
                                n_held_byte = init_cmd(cmd_off);
                            end
                            n_held_rs = 1'b0;
                            n_second  = 1'b0;
                            n_phase   = PH_SETUP;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase      = PH_IDLE;
                n_wait_count = '0;
                if (i_request) begin
                    n_held_byte = i_byte_value;
                    n_held_rs   = ~i_mode;
                    n_second    = 1'b0;
                    n_phase     = PH_SETUP;
                end
            end
        endcase
    end

    // Lines after this tick's update
    assign new_res.lcd_nibble = n_second ? n_held_byte[3:0] : n_held_byte[7:4];
    assign new_res.lcd_rs     = n_held_rs;
    assign new_res.lcd_e      = (n_phase == PH_STROBE);
    assign new_res.ready_res  = (n_phase == PH_IDLE);

    assign o_in_ready = ~r_skid_valid;
    assign in_accept  = i_in_valid & o_in_ready;
    assign out_pop    = r_out_valid & i_out_ready;

    // Advance the sequencer on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_POWER;
            r_wait_count <= '0;
            r_held_byte  <= 8'h00;
            r_held_rs    <= 1'b0;
            r_second     <= 1'b0;
            r_init_step  <= '0;
        end else if (in_accept) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_held_byte  <= n_held_byte;
            r_held_rs    <= n_held_rs;
            r_second     <= n_second;
            r_init_step  <= n_init_step;
        end
    end

    // Two-entry result buffer: output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_pop) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_pop) begin
                r_out <= new_res;
            end else begin
                r_skid <= new_res;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_lcd_nibble = r_out.lcd_nibble;
    assign o_lcd_rs     = r_out.lcd_rs;
    assign o_lcd_e      = r_out.lcd_e;
    assign o_ready_res  = r_out.ready_res;

    // Checks on the sequencer and the result buffer
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_ready |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost under stall");

    a_idle_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_init_step == INIT_DONE)
        else $error("idle reached before power-on sequence finished");

    a_power_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_POWER |-> r_held_byte == 8'h00 && r_init_step == '0)
        else $error("lines not clear during power-on wait");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init_step <= INIT_DONE)
        else $error("power-on step out of range");

endmodule
